// File: sv/cbwt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cubic Bezier wire tessellator.
// No dependencies; every other file imports this package.
package cbwt_pkg;

   // Coordinates are signed Q8.16, colors are plain 16-bit channels.
   typedef logic signed [23:0] coord_type;
   typedef logic [15:0] color_type;

   localparam coord_type COORD_MAX  = 24'sh7FFFFF;
   localparam coord_type COORD_MIN  = 24'sh800000;
   localparam coord_type LEAN_RESET = -24'sd6554;

   // Wire queue between front and back
   localparam int QDEPTH = 2;
   localparam int QAW    = $clog2(QDEPTH);

   // One wire with its control points already formed
   typedef struct packed {
      coord_type p0_x;
      coord_type p0_y;
      coord_type p0_z;
      coord_type c1_z;
      coord_type c2_z;
      coord_type p3_x;
      coord_type p3_y;
      coord_type p3_z;
      color_type red;
      color_type green;
      color_type blue;
      color_type alpha;
   } wire_type;

endpackage

// File: sv/cbwt_req_if.sv
`timescale 1ns / 1ps
// Input channel: one wire per item, valid/ready handshake.
// Depends on cbwt_pkg for the field types.
interface cbwt_req_if;
   import cbwt_pkg::*;

   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type start_z;
   coord_type end_x;
   coord_type end_y;
   coord_type end_z;
   color_type color_red;
   color_type color_green;
   color_type color_blue;
   color_type color_alpha;

   modport source (
      output valid, start_x, start_y, start_z, end_x, end_y, end_z,
             color_red, color_green, color_blue, color_alpha,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
             color_red, color_green, color_blue, color_alpha,
      output ready
   );
endinterface

// File: sv/cbwt_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: one line segment per item, valid/ready handshake.
// Depends on cbwt_pkg for the field types.
interface cbwt_rsp_if;
   import cbwt_pkg::*;

   logic      valid;
   logic      ready;
   coord_type seg_start_x;
   coord_type seg_start_y;
   coord_type seg_start_z;
   coord_type seg_end_x;
   coord_type seg_end_y;
   coord_type seg_end_z;
   color_type out_red;
   color_type out_green;
   color_type out_blue;
   color_type out_alpha;
   logic      last_segment;

   modport source (
      output valid, seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y,
             seg_end_z, out_red, out_green, out_blue, out_alpha, last_segment,
      input  ready
   );
   modport sink (
      input  valid, seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y,
             seg_end_z, out_red, out_green, out_blue, out_alpha, last_segment,
      output ready
   );
endinterface

// File: sv/cbwt_front.sv
`timescale 1ns / 1ps
// Front end: holds the lean offset register, accepts wires and forms the
// inner control points. Depends on cbwt_pkg and cbwt_req_if.
module cbwt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  cbwt_pkg::coord_type csr_write_data,
   cbwt_req_if.sink           req_chan,
   input  logic               q_ready,
   output logic               q_push,
   output cbwt_pkg::wire_type q_data
);
   import cbwt_pkg::*;

   coord_type lean_offset_ff;

   // Clamp a 25-bit sum into the coordinate range
   function automatic coord_type sat25(input logic signed [24:0] x);
      coord_type r;
      if (x > 25'(COORD_MAX)) begin
         r = COORD_MAX;
      end else if (x < 25'(COORD_MIN)) begin
         r = COORD_MIN;
      end else begin
         r = x[23:0];
      end
      return r;
   endfunction

   // Lean offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         lean_offset_ff <= LEAN_RESET;
      end else if (csr_write_enable) begin
         lean_offset_ff <= csr_write_data;
      end
   end

   // Accept a wire whenever the queue has room
   assign req_chan.ready = q_ready;
   assign q_push         = req_chan.valid && q_ready;

   // Form the control points: endpoints pushed along z by the lean offset
   always_comb begin
      q_data.p0_x  = req_chan.start_x;
      q_data.p0_y  = req_chan.start_y;
      q_data.p0_z  = req_chan.start_z;
      q_data.c1_z  = sat25(25'(req_chan.start_z) + 25'(lean_offset_ff));
      q_data.c2_z  = sat25(25'(req_chan.end_z) + 25'(lean_offset_ff));
      q_data.p3_x  = req_chan.end_x;
      q_data.p3_y  = req_chan.end_y;
      q_data.p3_z  = req_chan.end_z;
      q_data.red   = req_chan.color_red;
      q_data.green = req_chan.color_green;
      q_data.blue  = req_chan.color_blue;
      q_data.alpha = req_chan.color_alpha;
   end

endmodule

// File: sv/cbwt_queue.sv
`timescale 1ns / 1ps
// Short wire queue that decouples the front end from the segment engine.
// Depends on cbwt_pkg.
module cbwt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cbwt_pkg::wire_type push_data,
   output logic               push_ready,
   input  logic               pop,
   output logic               pop_valid,
   output cbwt_pkg::wire_type pop_data
);
   import cbwt_pkg::*;

   wire_type            slot_ff [QDEPTH];
   logic [QAW-1:0]      wr_ptr_ff;
   logic [QAW-1:0]      rd_ptr_ff;
   logic [QAW:0]        count_ff;
   logic [QAW:0]        count_in;

   assign push_ready = (count_ff != (QAW+1)'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Store the pushed wire
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QAW+1)'(QDEPTH))
      else $error("queue fill count beyond depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      QAW'(wr_ptr_ff - rd_ptr_ff) == count_ff[QAW-1:0])
      else $error("queue pointers disagree with fill count");

endmodule

// File: sv/cbwt_back.sv
`timescale 1ns / 1ps
// Segment engine: walks t = i/SEGMENTS for each queued wire, evaluates the
// Bezier point with a pipelined multiply-add and, while the output is not
// held, emits one segment per cycle. Depends on cbwt_pkg and cbwt_rsp_if.
module cbwt_back #(
   parameter int SEGMENTS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cbwt_pkg::wire_type q_data,
   output logic               q_pop,
   cbwt_rsp_if.source         rsp_chan
);
   import cbwt_pkg::*;

   localparam int    CW  = $clog2(SEGMENTS + 1);
   localparam longint DEN = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;

   typedef logic [SEGMENTS:0][3:0][16:0] wtab_type;

   // Bernstein weights in Q1.16 for every step, rounded half up
   function automatic wtab_type build_weights();
      wtab_type tab;
      longint   u;
      longint   ii;
      longint   num [4];
      tab = '0;
      for (int i = 0; i <= SEGMENTS; i++) begin
         ii     = longint'(i);
         u      = longint'(SEGMENTS) - ii;
         num[0] = u * u * u;
         num[1] = 3 * u * u * ii;
         num[2] = 3 * u * ii * ii;
         num[3] = ii * ii * ii;
         for (int k = 0; k < 4; k++) begin
            tab[i][k] = 17'(((num[k] << 16) + DEN / 2) / DEN);
         end
      end
      return tab;
   endfunction

   localparam wtab_type WTAB = build_weights();

   typedef struct packed {
      coord_type p0_x;
      coord_type p0_y;
      coord_type p0_z;
      color_type red;
      color_type green;
      color_type blue;
      color_type alpha;
      logic      first;
      logic      last;
   } meta_type;

   // Clamp a rounded 28-bit value into the coordinate range
   function automatic coord_type sat28(input logic signed [27:0] x);
      coord_type r;
      if (x > 28'(COORD_MAX)) begin
         r = COORD_MAX;
      end else if (x < 28'(COORD_MIN)) begin
         r = COORD_MIN;
      end else begin
         r = x[23:0];
      end
      return r;
   endfunction

   // Sequencer
   logic            active_ff;
   logic [CW-1:0]   idx_ff;
   wire_type        wire_ff;
   logic            adv;
   logic            wire_done;

   // Pipeline stages
   logic              s1_valid_ff;
   meta_type          s1_meta_ff;
   logic [3:0][16:0]  s1_w_ff;
   coord_type         s1_cp_ff [3][4];
   logic              s2_valid_ff;
   meta_type          s2_meta_ff;
   logic signed [41:0] s2_prod_ff [3][4];
   logic              s3_valid_ff;
   meta_type          s3_meta_ff;
   logic signed [42:0] s3_sum_ff [3][2];
   logic              s4_valid_ff;
   meta_type          s4_meta_ff;
   logic signed [43:0] s4_tot_ff [3];

   // Output register and running previous point
   logic              out_valid_ff;
   coord_type         out_start_ff [3];
   coord_type         out_end_ff [3];
   color_type         out_color_ff [4];
   logic              out_last_ff;
   coord_type         prev_ff [3];

   logic signed [43:0] rnd [3];
   logic signed [27:0] shf [3];
   coord_type          pt [3];

   // Whole pipeline moves unless the output is held
   assign adv       = !out_valid_ff || rsp_chan.ready;
   assign wire_done = !active_ff || (idx_ff == CW'(SEGMENTS));
   assign q_pop     = adv && wire_done && q_valid;

   // Step through the segments of the current wire, load the next at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else if (adv) begin
         if (wire_done) begin
            active_ff <= q_valid;
            idx_ff    <= CW'(1);
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         wire_ff <= q_data;
      end
   end

   // Valid bits of the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= active_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 1: look up weights, line up control points
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_meta_ff.p0_x  <= wire_ff.p0_x;
         s1_meta_ff.p0_y  <= wire_ff.p0_y;
         s1_meta_ff.p0_z  <= wire_ff.p0_z;
         s1_meta_ff.red   <= wire_ff.red;
         s1_meta_ff.green <= wire_ff.green;
         s1_meta_ff.blue  <= wire_ff.blue;
         s1_meta_ff.alpha <= wire_ff.alpha;
         s1_meta_ff.first <= (idx_ff == CW'(1));
         s1_meta_ff.last  <= (idx_ff == CW'(SEGMENTS));
         s1_w_ff          <= WTAB[idx_ff];
         s1_cp_ff[0][0]   <= wire_ff.p0_x;
         s1_cp_ff[0][1]   <= wire_ff.p0_x;
         s1_cp_ff[0][2]   <= wire_ff.p3_x;
         s1_cp_ff[0][3]   <= wire_ff.p3_x;
         s1_cp_ff[1][0]   <= wire_ff.p0_y;
         s1_cp_ff[1][1]   <= wire_ff.p0_y;
         s1_cp_ff[1][2]   <= wire_ff.p3_y;
         s1_cp_ff[1][3]   <= wire_ff.p3_y;
         s1_cp_ff[2][0]   <= wire_ff.p0_z;
         s1_cp_ff[2][1]   <= wire_ff.c1_z;
         s1_cp_ff[2][2]   <= wire_ff.c2_z;
         s1_cp_ff[2][3]   <= wire_ff.p3_z;
      end
   end

   // Stage 2: weight times control point, one multiplier per lane
   // Stage 3: pairwise sums; stage 4: total
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_meta_ff <= s1_meta_ff;
         s3_meta_ff <= s2_meta_ff;
         s4_meta_ff <= s3_meta_ff;
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
               s2_prod_ff[c][k] <= $signed({1'b0, s1_w_ff[k]}) * s1_cp_ff[c][k];
            end
            s3_sum_ff[c][0] <= 43'(s2_prod_ff[c][0]) + 43'(s2_prod_ff[c][1]);
            s3_sum_ff[c][1] <= 43'(s2_prod_ff[c][2]) + 43'(s2_prod_ff[c][3]);
            s4_tot_ff[c]    <= 44'(s3_sum_ff[c][0]) + 44'(s3_sum_ff[c][1]);
         end
      end
   end

   // Round half up to Q8.16 and saturate
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rnd[c] = s4_tot_ff[c] + 44'sd32768;
         shf[c] = 28'(rnd[c] >>> 16);
         pt[c]  = sat28(shf[c]);
      end
   end

   // Output stage: pair the new point with the previous one
   always_ff @(posedge clock) begin
      if (adv && s4_valid_ff) begin
         for (int c = 0; c < 3; c++) begin
            out_end_ff[c] <= pt[c];
            prev_ff[c]    <= pt[c];
         end
         out_start_ff[0] <= s4_meta_ff.first ? s4_meta_ff.p0_x : prev_ff[0];
         out_start_ff[1] <= s4_meta_ff.first ? s4_meta_ff.p0_y : prev_ff[1];
         out_start_ff[2] <= s4_meta_ff.first ? s4_meta_ff.p0_z : prev_ff[2];
         out_color_ff[0] <= s4_meta_ff.red;
         out_color_ff[1] <= s4_meta_ff.green;
         out_color_ff[2] <= s4_meta_ff.blue;
         out_color_ff[3] <= s4_meta_ff.alpha;
         out_last_ff     <= s4_meta_ff.last;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.seg_start_x  = out_start_ff[0];
   assign rsp_chan.seg_start_y  = out_start_ff[1];
   assign rsp_chan.seg_start_z  = out_start_ff[2];
   assign rsp_chan.seg_end_x    = out_end_ff[0];
   assign rsp_chan.seg_end_y    = out_end_ff[1];
   assign rsp_chan.seg_end_z    = out_end_ff[2];
   assign rsp_chan.out_red      = out_color_ff[0];
   assign rsp_chan.out_green    = out_color_ff[1];
   assign rsp_chan.out_blue     = out_color_ff[2];
   assign rsp_chan.out_alpha    = out_color_ff[3];
   assign rsp_chan.last_segment = out_last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff != '0) && (idx_ff <= CW'(SEGMENTS)))
      else $error("segment index out of range while active");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> active_ff && (idx_ff == CW'(1)))
      else $error("popped wire did not start at the first segment");

   a_first_last: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_meta_ff.first && s1_meta_ff.last) |-> (SEGMENTS == 1))
      else $error("segment marked both first and last");

endmodule

// File: sv/cubic_bezier_wire_tessellator_core.sv
`timescale 1ns / 1ps
// Cubic Bezier wire tessellator: one wire in, SEGMENTS line segments out.
// Each wire passes the queue and wire register, its segments then the evaluation
// stages and output register. Throughput: one segment per cycle while the output
// is not held, set by the single evaluation pipeline in the segment engine; a
// 2-wire queue buffers input. Reset (synchronous, active high) empties the queue
// and pipeline and sets the lean offset to -6554 (about -0.1 in Q8.16).
module cubic_bezier_wire_tessellator_core #(
   parameter int SEGMENTS = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  cbwt_pkg::coord_type csr_write_data,
   cbwt_req_if.sink            req_chan,
   cbwt_rsp_if.source          rsp_chan
);
   import cbwt_pkg::*;

   logic     q_push;
   logic     q_ready;
   logic     q_pop;
   logic     q_valid;
   wire_type q_in_data;
   wire_type q_out_data;

   // Accept wires and form control points
   cbwt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .q_ready          (q_ready),
      .q_push           (q_push),
      .q_data           (q_in_data)
   );

   // Buffer wires between the two halves
   cbwt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_out_data)
   );

   // Evaluate the curve and emit segments
   cbwt_back #(
      .SEGMENTS (SEGMENTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_out_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: bench/cbwt_segment_checker.sv
`timescale 1ns / 1ps
// Segment checker for the cubic Bezier wire tessellator: predicts every line segment of each
// accepted wire and compares it with the segments the block hands out.
// Depends on cbwt_pkg and the cbwt_req_if / cbwt_rsp_if interfaces.
module cbwt_segment_checker #(
   parameter int SEGMENTS = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  cbwt_pkg::coord_type csr_write_data,
   cbwt_req_if                 req_mon,
   cbwt_rsp_if                 rsp_mon,
   output int                  fail_count,
   output int                  segments_pending,
   output int                  segments_checked
);
   import cbwt_pkg::*;

   localparam longint CUBE = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
      color_type red;
      color_type green;
      color_type blue;
      color_type alpha;
      logic      is_last;
   } segment_type;

   // Bernstein weights in Q1.16, one row per curve step
   longint      bern_weight [0:SEGMENTS][0:3];
   coord_type   lean_offset_q;
   segment_type segments_due [$];
   int          fail_total    = 0;
   int          checked_total = 0;
   int          pending_q     = 0;

   assign fail_count       = fail_total;
   assign segments_pending = pending_q;
   assign segments_checked = checked_total;

   function automatic longint scale_weight(longint num);
      return ((num << 16) + CUBE / 2) / CUBE;
   endfunction

   function automatic coord_type clamp_coord(longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(v);
   endfunction

   // Build the weight table once
   initial begin
      longint u;
      for (int i = 0; i <= SEGMENTS; i++) begin
         u = SEGMENTS - i;
         bern_weight[i][0] = scale_weight(u * u * u);
         bern_weight[i][1] = scale_weight(3 * u * u * i);
         bern_weight[i][2] = scale_weight(3 * u * i * i);
         bern_weight[i][3] = scale_weight(longint'(i) * i * i);
      end
   end

   // Evaluate the curve of the wire on the input channel and queue its segments
   task automatic queue_wire_segments();
      longint      p0 [3];
      longint      p1 [3];
      longint      p2 [3];
      longint      p3 [3];
      coord_type   prev [3];
      coord_type   pt [3];
      longint      acc;
      segment_type seg;
      p0[0] = req_mon.start_x;
      p0[1] = req_mon.start_y;
      p0[2] = req_mon.start_z;
      p3[0] = req_mon.end_x;
      p3[1] = req_mon.end_y;
      p3[2] = req_mon.end_z;
      p1 = p0;
      p2 = p3;
      // inner control points lean along z, clamped to the coordinate range
      p1[2] = clamp_coord(p0[2] + lean_offset_q);
      p2[2] = clamp_coord(p3[2] + lean_offset_q);
      for (int c = 0; c < 3; c++) prev[c] = coord_type'(p0[c]);
      for (int i = 1; i <= SEGMENTS; i++) begin
         for (int c = 0; c < 3; c++) begin
            acc = bern_weight[i][0] * p0[c] + bern_weight[i][1] * p1[c]
                + bern_weight[i][2] * p2[c] + bern_weight[i][3] * p3[c];
            // round half up to Q8.16, then clamp
            pt[c] = clamp_coord((acc + 64'sd32768) >>> 16);
         end
         seg.start_x = prev[0];
         seg.start_y = prev[1];
         seg.start_z = prev[2];
         seg.end_x   = pt[0];
         seg.end_y   = pt[1];
         seg.end_z   = pt[2];
         seg.red     = req_mon.color_red;
         seg.green   = req_mon.color_green;
         seg.blue    = req_mon.color_blue;
         seg.alpha   = req_mon.color_alpha;
         seg.is_last = (i == SEGMENTS);
         segments_due.insert(segments_due.size(), seg);
         prev = pt;
      end
   endtask

   task automatic check_field(string name, logic signed [24:0] want, logic signed [24:0] got);
      if (got !== want) begin
         fail_total++;
         $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Compare the segment on the result channel with the oldest prediction
   task automatic compare_segment();
      segment_type want;
      if (segments_due.size() == 0) begin
         fail_total++;
         $display("%0t ns: unexpected segment: expected none, actual end (%0d,%0d,%0d)",
                  $time, rsp_mon.seg_end_x, rsp_mon.seg_end_y, rsp_mon.seg_end_z);
      end else begin
         want = segments_due.pop_front();
         check_field("seg_start_x", want.start_x, rsp_mon.seg_start_x);
         check_field("seg_start_y", want.start_y, rsp_mon.seg_start_y);
         check_field("seg_start_z", want.start_z, rsp_mon.seg_start_z);
         check_field("seg_end_x", want.end_x, rsp_mon.seg_end_x);
         check_field("seg_end_y", want.end_y, rsp_mon.seg_end_y);
         check_field("seg_end_z", want.end_z, rsp_mon.seg_end_z);
         check_field("out_red", want.red, rsp_mon.out_red);
         check_field("out_green", want.green, rsp_mon.out_green);
         check_field("out_blue", want.blue, rsp_mon.out_blue);
         check_field("out_alpha", want.alpha, rsp_mon.out_alpha);
         check_field("last_segment", want.is_last, rsp_mon.last_segment);
         checked_total++;
      end
   endtask

   // Track the lean register, predict on each accepted wire, check each segment
   always @(posedge clock) begin
      if (reset) begin
         lean_offset_q = LEAN_RESET;
         segments_due.delete();
      end else begin
         if (csr_write_enable) lean_offset_q = csr_write_data;
         if (req_mon.valid && req_mon.ready) queue_wire_segments();
         if (rsp_mon.valid && rsp_mon.ready) compare_segment();
      end
      pending_q <= segments_due.size();
   end

endmodule

// File: bench/tb_cubic_bezier_wire_tessellator_core.sv
`timescale 1ns / 1ps
// Testbench top for cubic_bezier_wire_tessellator_core: drives wires and lean-offset writes
// with random idling on both channels and reports the verdict.
// Depends on cbwt_pkg, both channel interfaces, the DUT and cbwt_segment_checker.
module tb_cubic_bezier_wire_tessellator_core;
   import cbwt_pkg::*;

   localparam int SEGMENTS      = 14;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_WIRES   = 30;
   localparam int SETTLE_CYCLES = 20;

   logic      clock;
   logic      reset;
   logic      csr_write_enable;
   coord_type csr_write_data;
   int        fail_count;
   int        segments_pending;
   int        segments_checked;
   bit        gaps_on    = 0;
   bit        stalls_on  = 0;
   int        wires_sent = 0;
   int        lean_writes = 0;

   cbwt_req_if req_if ();
   cbwt_rsp_if rsp_if ();

   cubic_bezier_wire_tessellator_core #(
      .SEGMENTS(SEGMENTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   cbwt_segment_checker #(
      .SEGMENTS(SEGMENTS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_mon(req_if),
      .rsp_mon(rsp_if),
      .fail_count(fail_count),
      .segments_pending(segments_pending),
      .segments_checked(segments_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one wire, after an optional gap, and hold it until accepted
   task automatic send_wire(coord_type sx, sy, sz, ex, ey, ez, color_type r, g, b, a);
      int gap;
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.start_x     <= sx;
      req_if.start_y     <= sy;
      req_if.start_z     <= sz;
      req_if.end_x       <= ex;
      req_if.end_y       <= ey;
      req_if.end_z       <= ez;
      req_if.color_red   <= r;
      req_if.color_green <= g;
      req_if.color_blue  <= b;
      req_if.color_alpha <= a;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      wires_sent++;
   endtask

   // Drop valid and hold off until every predicted segment has come back
   task automatic drain_segments();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (segments_pending != 0);
   endtask

   // Write the lean offset once the block is idle
   task automatic write_lean(coord_type v);
      drain_segments();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      lean_writes++;
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3, 4: return coord_type'(int'($urandom_range(0, 262144)) - 131072);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic color_type rand_color();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return color_type'($urandom);
      endcase
   endfunction

   function automatic coord_type rand_lean(int pick);
      case (pick)
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3: return LEAN_RESET;
         4: return coord_type'(int'($urandom_range(0, 262144)) - 131072);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic send_random_wire();
      send_wire(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_color(), rand_color(), rand_color(), rand_color());
   endtask

   // Result side: when stalls are on, stall a random number of cycles before taking each item
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = stalls_on ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   // Watchdog: end the run if it hangs
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d segments still due", cycle_count,
               segments_pending);
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus
   initial begin
      int mode;
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      req_if.valid       <= 1'b0;
      req_if.start_x     <= '0;
      req_if.start_y     <= '0;
      req_if.start_z     <= '0;
      req_if.end_x       <= '0;
      req_if.end_y       <= '0;
      req_if.end_z       <= '0;
      req_if.color_red   <= '0;
      req_if.color_green <= '0;
      req_if.color_blue  <= '0;
      req_if.color_alpha <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, lean at its reset value, no idling
      send_wire('0, '0, '0, '0, '0, '0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_wire(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_wire(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_wire(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_wire(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_wire(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555,
                16'h1234, 16'h8000, 16'h7FFF, 16'h0001);
      send_wire(24'sd1, -24'sd1, 24'sd0, -24'sd1, 24'sd1, 24'sd1,
                16'h0001, 16'h0002, 16'h0004, 16'h0008);
      send_wire('0, '0, '0, 24'sd65536, -24'sd65536, 24'sd32768,
                16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0);

      // Largest lean: control points of the first wire clamp high
      write_lean(COORD_MAX);
      send_wire(24'sd1000, -24'sd1000, COORD_MAX, 24'sd5000, 24'sd7000, COORD_MAX,
                16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      send_wire('0, '0, '0, 24'sd131072, 24'sd131072, '0,
                16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_wire('0, '0, COORD_MIN, '0, '0, COORD_MIN,
                16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);

      // Smallest lean: control points clamp low on the first and third wires
      write_lean(COORD_MIN);
      send_wire(-24'sd3000, 24'sd3000, COORD_MIN, 24'sd9, -24'sd9, COORD_MIN,
                16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
      send_wire('0, '0, COORD_MAX, '0, '0, COORD_MAX,
                16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_wire('0, '0, -24'sd1, '0, '0, '0,
                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);

      // No lean: straight cubic between the endpoints
      write_lean('0);
      send_wire(-24'sd65536, 24'sd327680, 24'sd12345, 24'sd196608, -24'sd98304, -24'sd54321,
                16'hCAFE, 16'h0BAD, 16'hF00D, 16'hBEEF);
      send_wire(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

      // Random phases: new lean and idling mode each time, drain in between
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_lean(rand_lean(phase == 0 ? 5 : $urandom_range(0, 5)));
         mode      = (phase == 0) ? 3 : $urandom_range(0, 3);
         gaps_on   = mode[0];
         stalls_on = mode[1];
         repeat (PHASE_WIRES) send_random_wire();
      end

      // Wait out the last segments and let the pipeline settle
      drain_segments();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d wires over %0d lean writes, %0d segments checked",
               wires_sent, lean_writes, segments_checked);
      $display("Lean settings included reset, zero, both extremes and random values");
      if (fail_count == 0 && segments_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
sv/cbwt_pkg.sv
sv/cbwt_req_if.sv
sv/cbwt_rsp_if.sv
sv/cbwt_front.sv
sv/cbwt_queue.sv
sv/cbwt_back.sv
sv/cubic_bezier_wire_tessellator_core.sv
bench/cbwt_segment_checker.sv
bench/tb_cubic_bezier_wire_tessellator_core.sv
